FILE: hw/rtl/rgb_quad_to_nv12_unit_macros.svh
// Assertion macros for the RGB quad to NV12 converter.
// Used by the top level only; depends on nothing else.
`ifndef RGB_QUAD_TO_NV12_UNIT_MACROS_SVH
`define RGB_QUAD_TO_NV12_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RQN_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqn assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RQN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqn assertion failed");

`endif

FILE: hw/rtl/rqn_pkg.sv
// Shared types and constants for the RGB quad to NV12 converter.
// Holds the pixel type, field widths and BT.601 fixed-point coefficients.
`timescale 1ns / 1ps
`default_nettype none

package rqn_pkg;

  localparam int COMP_W      = 8;
  localparam int QUAD_PIXELS = 4;
  localparam int PIXEL_BITS  = 3 * COMP_W;
  localparam int IN_BITS     = QUAD_PIXELS * PIXEL_BITS;
  localparam int OUT_BITS    = (QUAD_PIXELS + 2) * COMP_W;

  localparam int LUMA_W = 25;
  localparam int SUM_W  = 10;
  localparam int CHR_W  = 28;

  localparam logic [LUMA_W-1:0] LUMA_RED    = 25'd16843;
  localparam logic [LUMA_W-1:0] LUMA_GREEN  = 25'd33030;
  localparam logic [LUMA_W-1:0] LUMA_BLUE   = 25'd6423;
  localparam logic [LUMA_W-1:0] LUMA_OFFSET = 25'd1081344;

  localparam logic signed [CHR_W-1:0] CB_RED    = -28'sd9699;
  localparam logic signed [CHR_W-1:0] CB_GREEN  = -28'sd19071;
  localparam logic signed [CHR_W-1:0] CB_BLUE   = 28'sd28770;
  localparam logic signed [CHR_W-1:0] CR_RED    = 28'sd28770;
  localparam logic signed [CHR_W-1:0] CR_GREEN  = -28'sd24117;
  localparam logic signed [CHR_W-1:0] CR_BLUE   = -28'sd4653;
  // Four times the per-pixel chroma offset, since the quad is summed.
  localparam logic signed [CHR_W-1:0] CHROMA_OFFSET4 = 28'sd34078720;

  typedef logic [COMP_W-1:0] byte_t;

  typedef struct packed {
    byte_t blue;
    byte_t green;
    byte_t red;
  } pixel_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rqn_luma.sv
// Luma of one pixel: weighted RGB sum plus offset, truncated and saturated.
// Depends on rqn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqn_luma
  import rqn_pkg::*;
(
  input  pixel_t px,
  output byte_t  luma
);

  logic [LUMA_W-1:0] y_sum;

  always_comb begin
    y_sum = LUMA_RED * {{(LUMA_W-COMP_W){1'b0}}, px.red}
          + LUMA_GREEN * {{(LUMA_W-COMP_W){1'b0}}, px.green}
          + LUMA_BLUE * {{(LUMA_W-COMP_W){1'b0}}, px.blue}
          + LUMA_OFFSET;
    if (y_sum[LUMA_W-1]) begin
      luma = '1;
    end else begin
      luma = y_sum[LUMA_W-2:16];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rqn_chroma.sv
// Averaged Cb and Cr of a 2x2 quad, truncated and saturated to a byte.
// Sums each color over the quad first, then applies the coefficients once.
// Depends on rqn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqn_chroma
  import rqn_pkg::*;
(
  input  pixel_t px [QUAD_PIXELS],
  output byte_t  blue_chroma,
  output byte_t  red_chroma
);

  logic [SUM_W-1:0] red_sum;
  logic [SUM_W-1:0] green_sum;
  logic [SUM_W-1:0] blue_sum;
  logic signed [CHR_W-1:0] red_ext;
  logic signed [CHR_W-1:0] green_ext;
  logic signed [CHR_W-1:0] blue_ext;
  logic signed [CHR_W-1:0] cb_sum;
  logic signed [CHR_W-1:0] cr_sum;

  function automatic byte_t sat_chroma(input logic signed [CHR_W-1:0] v);
    byte_t r;
    if (v[CHR_W-1]) begin
      r = '0;
    end else if (v[CHR_W-2:18] > 9'd255) begin
      r = '1;
    end else begin
      r = v[25:18];
    end
    return r;
  endfunction

  always_comb begin
    red_sum   = '0;
    green_sum = '0;
    blue_sum  = '0;
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      red_sum   = red_sum + {{(SUM_W-COMP_W){1'b0}}, px[p].red};
      green_sum = green_sum + {{(SUM_W-COMP_W){1'b0}}, px[p].green};
      blue_sum  = blue_sum + {{(SUM_W-COMP_W){1'b0}}, px[p].blue};
    end
    red_ext   = $signed({{(CHR_W-SUM_W){1'b0}}, red_sum});
    green_ext = $signed({{(CHR_W-SUM_W){1'b0}}, green_sum});
    blue_ext  = $signed({{(CHR_W-SUM_W){1'b0}}, blue_sum});
    cb_sum = CB_RED * red_ext + CB_GREEN * green_ext + CB_BLUE * blue_ext
           + CHROMA_OFFSET4;
    cr_sum = CR_RED * red_ext + CR_GREEN * green_ext + CR_BLUE * blue_ext
           + CHROMA_OFFSET4;
    blue_chroma = sat_chroma(cb_sum);
    red_chroma  = sat_chroma(cr_sum);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_quad_to_nv12_unit.sv
// Top level of the RGB quad to NV12 converter: stream ports and pipeline.
// Depends on rqn_pkg, rqn_luma, rqn_chroma and the assertion macro header.
//
// The unit converts one 2x2 quad of 8-bit RGB pixels per transaction into four
// BT.601 studio-range luma bytes and one averaged Cb/Cr pair. It accepts one
// quad per clock cycle while the output is not stalled: the quad is captured
// in an input register, converted by constant-coefficient logic and held in
// the result register, which lets a new quad enter while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_quad_to_nv12_unit_macros.svh"

module rgb_quad_to_nv12_unit
  import rqn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0 up: top_left red, green, blue; top_right red, green,
  // blue; bottom_left red, green, blue; bottom_right red, green, blue.
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0 up: top_left_luma, top_right_luma, bottom_left_luma,
  // bottom_right_luma, blue_chroma, red_chroma.
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  pixel_t px_in [QUAD_PIXELS];
  pixel_t stage_px [QUAD_PIXELS];
  logic   stage_valid;
  logic   stage_load;
  logic   out_load;
  byte_t  luma [QUAD_PIXELS];
  byte_t  blue_chroma;
  byte_t  red_chroma;
  logic [OUT_BITS-1:0] result;

  always_comb begin
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      px_in[p].red   = s_axis_tdata[p*PIXEL_BITS +: COMP_W];
      px_in[p].green = s_axis_tdata[p*PIXEL_BITS + COMP_W +: COMP_W];
      px_in[p].blue  = s_axis_tdata[p*PIXEL_BITS + 2*COMP_W +: COMP_W];
    end
  end

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign stage_load    = !stage_valid || out_load;
  assign s_axis_tready = stage_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && stage_load) begin
      stage_px <= px_in;
    end
  end

  for (genvar p = 0; p < QUAD_PIXELS; p++) begin : g_luma
    rqn_luma u_luma (
      .px   (stage_px[p]),
      .luma (luma[p])
    );
  end

  rqn_chroma u_chroma (
    .px          (stage_px),
    .blue_chroma (blue_chroma),
    .red_chroma  (red_chroma)
  );

  always_comb begin
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      result[p*COMP_W +: COMP_W] = luma[p];
    end
    result[QUAD_PIXELS*COMP_W +: COMP_W]     = blue_chroma;
    result[(QUAD_PIXELS+1)*COMP_W +: COMP_W] = red_chroma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      m_axis_tdata <= result;
    end
  end

  `RQN_ASSERT_IMPLIES(a_no_accept_when_full, clk, rst,
    s_axis_tvalid && s_axis_tready, !(stage_valid && m_axis_tvalid && !m_axis_tready))
  `RQN_ASSERT_IMPLIES(a_output_from_stage, clk, rst,
    m_axis_tvalid && !$past(m_axis_tvalid), $past(stage_valid))
  `RQN_ASSERT_NEXT(a_result_loaded, clk, rst,
    out_load && stage_valid, m_axis_tvalid && (m_axis_tdata == $past(result)))

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_quad_to_nv12_unit: stream stimulus, a scoreboard class
// that predicts the BT.601 luma and averaged chroma, and random flow control.
// Depends on rqn_pkg and the unit under test; reads no files.

module testbench;
  import rqn_pkg::*;

  typedef pixel_t [QUAD_PIXELS-1:0] quad_t;
  typedef logic [OUT_BITS-1:0] nv12_t;

  // BT.601 studio-range coefficients scaled by 2^16.
  localparam longint Y_FROM_R  = 16843;
  localparam longint Y_FROM_G  = 33030;
  localparam longint Y_FROM_B  = 6423;
  localparam longint Y_BIAS    = 1081344;
  localparam longint CB_FROM_R = -9699;
  localparam longint CB_FROM_G = -19071;
  localparam longint CB_FROM_B = 28770;
  localparam longint CR_FROM_R = 28770;
  localparam longint CR_FROM_G = -24117;
  localparam longint CR_FROM_B = -4653;
  localparam longint C_BIAS    = 8519680;
  localparam int     NV12_FIELDS = QUAD_PIXELS + 2;
  localparam string  FIELD_NAME[NV12_FIELDS] = '{"top_left_luma", "top_right_luma",
    "bottom_left_luma", "bottom_right_luma", "blue_chroma", "red_chroma"};

  class nv12_checker;
    nv12_t expected_q[$];
    int    mismatches = 0;
    int    compared = 0;

    static function byte_t saturate(longint v);
      if (v < 0) begin
        return '0;
      end
      if (v > 255) begin
        return 8'hFF;
      end
      return byte_t'(v);
    endfunction

    function nv12_t convert(quad_t q);
      longint r, g, b, y, cb_acc, cr_acc;
      nv12_t  res;
      cb_acc = 0;
      cr_acc = 0;
      res = '0;
      for (int p = 0; p < QUAD_PIXELS; p++) begin
        r = longint'({56'd0, q[p].red});
        g = longint'({56'd0, q[p].green});
        b = longint'({56'd0, q[p].blue});
        y = Y_FROM_R * r + Y_FROM_G * g + Y_FROM_B * b + Y_BIAS;
        res[p*COMP_W +: COMP_W] = saturate(y / 65536);
        cb_acc += CB_FROM_R * r + CB_FROM_G * g + CB_FROM_B * b + C_BIAS;
        cr_acc += CR_FROM_R * r + CR_FROM_G * g + CR_FROM_B * b + C_BIAS;
      end
      res[QUAD_PIXELS*COMP_W +: COMP_W]     = saturate(cb_acc / 262144);
      res[(QUAD_PIXELS+1)*COMP_W +: COMP_W] = saturate(cr_acc / 262144);
      return res;
    endfunction

    function void note_quad(quad_t q);
      expected_q.push_back(convert(q));
    endfunction

    function void check_nv12(nv12_t got);
      nv12_t want;
      bit    bad;
      compared++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result transaction: %h", got);
        end
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      bad = 1'b0;
      for (int f = 0; f < NV12_FIELDS; f++) begin
        if (got[f*COMP_W +: COMP_W] !== want[f*COMP_W +: COMP_W]) begin
          bad = 1'b1;
          if (mismatches < 10) begin
            $display("Result %0d, %s: expected %0d, got %0d", compared, FIELD_NAME[f],
                     want[f*COMP_W +: COMP_W], got[f*COMP_W +: COMP_W]);
          end
        end
      end
      if (bad) begin
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  nv12_checker sb = new();
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int quads_sent = 0;
  int directed_count = 0;

  rgb_quad_to_nv12_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_quad(quad_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_nv12(m_axis_tdata);
      end
    end
  end

  task automatic send_quad(input quad_t q);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk); while (!s_axis_tready);
    quads_sent++;
  endtask

  function automatic quad_t uniform_quad(input byte_t r, input byte_t g, input byte_t b);
    quad_t q;
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      q[p].red   = r;
      q[p].green = g;
      q[p].blue  = b;
    end
    return q;
  endfunction

  // Mix of fully random quads, saturated corners, smooth patches and grey quads.
  function automatic quad_t random_quad();
    logic [IN_BITS-1:0] v;
    int kind, val;
    int base[3];
    kind = $urandom_range(0, 3);
    for (int c = 0; c < 3; c++) begin
      base[c] = $urandom_range(0, 255);
    end
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      val = $urandom_range(0, 255);
      for (int c = 0; c < 3; c++) begin
        case (kind)
          0: val = $urandom_range(0, 255);
          1: begin
            val = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(253, 255);
          end
          2: begin
            val = base[c] + $urandom_range(0, 16) - 8;
            val = (val < 0) ? 0 : ((val > 255) ? 255 : val);
          end
          default: ;
        endcase
        v[(p*3 + c)*COMP_W +: COMP_W] = byte_t'(val);
      end
    end
    return quad_t'(v);
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_quad(random_quad());
    end
  endtask

  initial begin
    quad_t q;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 7;
    sink_stall_pct  = 63;
    send_quad(uniform_quad(8'h00, 8'h00, 8'h00));
    send_quad(uniform_quad(8'hFF, 8'hFF, 8'hFF));
    send_quad(uniform_quad(8'hFF, 8'h00, 8'h00));
    send_quad(uniform_quad(8'h00, 8'hFF, 8'h00));
    send_quad(uniform_quad(8'h00, 8'h00, 8'hFF));
    send_quad(uniform_quad(8'hFF, 8'hFF, 8'h00));
    send_quad(uniform_quad(8'h00, 8'hFF, 8'hFF));
    send_quad(uniform_quad(8'hFF, 8'h00, 8'hFF));
    send_quad(uniform_quad(8'h55, 8'hAA, 8'h55));
    send_quad(uniform_quad(8'hAA, 8'h55, 8'hAA));
    send_quad(uniform_quad(8'h80, 8'h80, 8'h80));
    send_quad(uniform_quad(8'h01, 8'h01, 8'h01));
    send_quad(uniform_quad(8'hFE, 8'hFE, 8'hFE));
    for (int p = 0; p < QUAD_PIXELS; p++) begin
      q = '0;
      q[p] = {3{8'hFF}};
      send_quad(q);
    end
    q = '0;
    q[0] = {3{8'hFF}};
    q[3] = {3{8'hFF}};
    send_quad(q);
    send_quad(~q);
    directed_count = quads_sent;
    send_random(130);

    sender_idle_pct = 63;
    sink_stall_pct  = 7;
    send_random(130);

    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_random(130);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d quads (%0d directed, the rest random) under three flow-control mixes;",
             quads_sent, directed_count);
    $display("compared %0d result transactions, %0d mismatched.", sb.compared, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("rgb_quad_to_nv12_unit: match");
    end else begin
      $display("rgb_quad_to_nv12_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding.", sb.expected_q.size());
    $display("rgb_quad_to_nv12_unit: mismatch");
    $finish;
  end

endmodule
